@@ hw/rtl/gregorian_weekday_week_start_day_count_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian weekday block
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_WEEKDAY_WEEK_START_DAY_COUNT_DEFINES_SVH
`define GREGORIAN_WEEKDAY_WEEK_START_DAY_COUNT_DEFINES_SVH

// same-cycle implication
`define GWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gwd_pkg.sv @@
// ----------------------------------------------------------------------------
// gwd_pkg
// Types, constants and calendar tables of the Gregorian weekday block.
// ----------------------------------------------------------------------------
package gwd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int COUNT_W = 22;

  localparam int COUNT_MAX     = 4194303;
  localparam int CYCLE_OFFSET  = 400;   // whole weekday cycle of years
  localparam int DAYS_PER_YEAR = 365;
  localparam int LEAP_FEB_LEN  = 29;

  // x / 25 = (x * RECIP25) >> RECIP25_SHIFT, exact for x < 4681
  localparam int RECIP25       = 2622;
  localparam int RECIP25_SHIFT = 16;
  // x / 7 = (x * RECIP7) >> RECIP7_SHIFT, exact for x < 32768
  localparam int RECIP7        = 37450;
  localparam int RECIP7_SHIFT  = 18;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [WDAY_W-1:0] WD_SUNDAY = 3'd1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [WDAY_W-1:0]  weekday;
    logic [YEAR_W-1:0]  sunday_year;
    logic [MONTH_W-1:0] sunday_month;
    logic [DAY_W-1:0]   sunday_day;
    logic [COUNT_W-1:0] days_since_epoch;
  } result_t;

  // after stage 1: tables looked up, divisions by 25 done
  typedef struct packed {
    date_t       date;
    logic [5:0]  mterm;     // 2*mm + 3*(mm+1)/5
    logic [14:0] ya;        // adjusted year + 400
    logic [12:0] q4a;       // ya / 4
    logic [7:0]  qa25;      // ya / 100
    logic [11:0] q4p;       // (year-1) / 4
    logic [7:0]  qp25;      // (year-1) / 100
    logic [7:0]  qy25;      // year / 100
    logic [22:0] yday;      // 365 * (year-1)
    logic [8:0]  days_before;  // days before month
  } s1_t;

  // after stage 2: weekday sum and day count
  typedef struct packed {
    date_t              date;
    logic               leap;
    logic [14:0]        wsum;
    logic [COUNT_W-1:0] total;
  } s2_t;

  // after stage 3: quotient of the weekday sum by 7
  typedef struct packed {
    date_t              date;
    logic               leap;
    logic [14:0]        wsum;
    logic [12:0]        q7;
    logic [COUNT_W-1:0] total;
  } s3_t;

  // month term of the weekday sum, January and February as months 13, 14
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd0:    t = 6'd0;
      4'd1:    t = 6'd34;
      4'd2:    t = 6'd37;
      4'd3:    t = 6'd8;
      4'd4:    t = 6'd11;
      4'd5:    t = 6'd13;
      4'd6:    t = 6'd16;
      4'd7:    t = 6'd18;
      4'd8:    t = 6'd21;
      4'd9:    t = 6'd24;
      4'd10:   t = 6'd26;
      4'd11:   t = 6'd29;
      4'd12:   t = 6'd31;
      4'd13:   t = 6'd34;
      4'd14:   t = 6'd37;
      default: t = 6'd39;
    endcase
    return t;
  endfunction

  // days before month in a common year; past December counts a full year
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] b;
    case (m)
      4'd0, 4'd1: b = 9'd0;
      4'd2:       b = 9'd31;
      4'd3:       b = 9'd59;
      4'd4:       b = 9'd90;
      4'd5:       b = 9'd120;
      4'd6:       b = 9'd151;
      4'd7:       b = 9'd181;
      4'd8:       b = 9'd212;
      4'd9:       b = 9'd243;
      4'd10:      b = 9'd273;
      4'd11:      b = 9'd304;
      4'd12:      b = 9'd334;
      default:    b = 9'd365;
    endcase
    return b;
  endfunction

  // common-year month length; codes that are no month read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] l;
    case (m)
      4'd2:                    l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
      default:                 l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

@@ hw/rtl/gwd_date_if.sv @@
// ----------------------------------------------------------------------------
// gwd_date_if
// Valid/ready channel carrying one Gregorian date.
// ----------------------------------------------------------------------------
interface gwd_date_if import gwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  date_year;
  logic [MONTH_W-1:0] date_month;
  logic [DAY_W-1:0]   date_day;

  modport source (output valid, output date_year, output date_month,
                  output date_day, input ready);
  modport sink   (input valid, input date_year, input date_month,
                  input date_day, output ready);
endinterface

@@ hw/rtl/gwd_result_if.sv @@
// ----------------------------------------------------------------------------
// gwd_result_if
// Valid/ready channel carrying weekday, week-start Sunday and day count.
// ----------------------------------------------------------------------------
interface gwd_result_if import gwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WDAY_W-1:0]  weekday;
  logic [YEAR_W-1:0]  sunday_year;
  logic [MONTH_W-1:0] sunday_month;
  logic [DAY_W-1:0]   sunday_day;
  logic [COUNT_W-1:0] days_since_epoch;

  modport source (output valid, output weekday, output sunday_year,
                  output sunday_month, output sunday_day,
                  output days_since_epoch, input ready);
  modport sink   (input valid, input weekday, input sunday_year,
                  input sunday_month, input sunday_day,
                  input days_since_epoch, output ready);
endinterface

@@ hw/rtl/gwd_prep.sv @@
// ----------------------------------------------------------------------------
// gwd_prep
// Stage 1: month tables, adjusted year and reciprocal divisions by 100.
// ----------------------------------------------------------------------------
module gwd_prep import gwd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  logic  in_valid,
  input  date_t in_date,
  output logic  out_valid,
  output s1_t   out_data
);

  logic        early;
  logic [13:0] yp;
  s1_t         s1_next;
  logic [24:0] prod_a;
  logic [23:0] prod_p;
  logic [23:0] prod_y;

  always_comb begin
    early = (in_date.month == MON_JAN) || (in_date.month == MON_FEB);
    yp    = (in_date.year == '0) ? '0 : in_date.year - 14'd1;

    s1_next.date        = in_date;
    s1_next.mterm       = month_term(in_date.month);
    s1_next.days_before = days_before_month(in_date.month);
    s1_next.ya          = 15'(in_date.year) + 15'(CYCLE_OFFSET) - 15'(early);
    s1_next.q4a         = s1_next.ya[14:2];
    s1_next.q4p         = yp[13:2];

    // divide the quarter by 25 to get the hundreds
    prod_a = 25'(s1_next.q4a) * 25'(RECIP25);
    prod_p = 24'(s1_next.q4p) * 24'(RECIP25);
    prod_y = 24'(in_date.year[13:2]) * 24'(RECIP25);
    s1_next.qa25 = prod_a[RECIP25_SHIFT +: 8];
    s1_next.qp25 = prod_p[RECIP25_SHIFT +: 8];
    s1_next.qy25 = prod_y[RECIP25_SHIFT +: 8];

    s1_next.yday = 23'(yp) * 23'(DAYS_PER_YEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= s1_next;
    end
  end

endmodule

@@ hw/rtl/gwd_sum.sv @@
// ----------------------------------------------------------------------------
// gwd_sum
// Stage 2: leap test, weekday sum and saturated day count since year 1.
// ----------------------------------------------------------------------------
module gwd_sum import gwd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic in_valid,
  input  s1_t  in_data,
  output logic out_valid,
  output s2_t  out_data
);

  logic        div4;
  logic        cent;
  logic [22:0] dterm;
  logic [22:0] sum;
  s2_t         s2_next;

  always_comb begin
    div4 = (in_data.date.year[1:0] == 2'b00);
    // multiple of 100: multiple of 4 with a quarter that is a multiple of 25
    cent = div4 && (in_data.date.year[13:2] == 12'(in_data.qy25) * 12'd25);
    dterm = (in_data.date.day == '0) ? '0 : 23'(in_data.date.day) - 23'd1;

    s2_next.date = in_data.date;
    s2_next.leap = div4 && (!cent || (in_data.qy25[1:0] == 2'b00));
    s2_next.wsum = 15'(in_data.date.day) + 15'(in_data.mterm) + in_data.ya
                 + 15'(in_data.q4a) - 15'(in_data.qa25) + 15'(in_data.qa25[7:2]);

    sum = in_data.yday + 23'(in_data.q4p) - 23'(in_data.qp25)
        + 23'(in_data.qp25[7:2]) + 23'(in_data.days_before) + dterm
        + 23'(s2_next.leap && (in_data.date.month >= MON_MAR));
    s2_next.total = sum[22] ? COUNT_W'(COUNT_MAX) : sum[21:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

@@ hw/rtl/gwd_resolve.sv @@
// ----------------------------------------------------------------------------
// gwd_resolve
// Stages 3 and 4: weekday sum mod 7, then weekday and week-start Sunday.
// ----------------------------------------------------------------------------
module gwd_resolve import gwd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load_q,
  input  logic    load_out,
  input  logic    in_valid,
  input  s2_t     in_data,
  output logic    q_valid,
  output logic    out_valid,
  output result_t out_data
);

  s3_t                s3;
  s3_t                s3_next;
  logic [30:0]        prod7;
  logic [15:0]        seven_q;
  logic [2:0]         rem7;
  logic [WDAY_W-1:0]  wd;
  logic [MONTH_W-1:0] pm;
  logic [DAY_W-1:0]   plen;
  result_t            res_next;

  always_comb begin
    prod7 = 31'(in_data.wsum) * 31'(RECIP7);
    s3_next.date  = in_data.date;
    s3_next.leap  = in_data.leap;
    s3_next.wsum  = in_data.wsum;
    s3_next.total = in_data.total;
    s3_next.q7    = prod7[RECIP7_SHIFT +: 13];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load_q) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_q && in_valid) begin
      s3 <= s3_next;
    end
  end

  always_comb begin
    // remainder lies in 0..6, so the low three bits are enough
    seven_q = {s3.q7, 3'b000} - {3'b000, s3.q7};
    rem7    = s3.wsum[2:0] - seven_q[2:0];
    wd      = (rem7 == 3'd6) ? WD_SUNDAY : rem7 + 3'd2;

    pm   = s3.date.month - 4'd1;
    plen = (pm == MON_FEB && s3.leap) ? DAY_W'(LEAP_FEB_LEN) : month_len(pm);

    res_next.weekday          = wd;
    res_next.days_since_epoch = s3.total;
    if (s3.date.day >= DAY_W'(wd)) begin
      res_next.sunday_year  = s3.date.year;
      res_next.sunday_month = s3.date.month;
      res_next.sunday_day   = s3.date.day - DAY_W'(wd) + 5'd1;
    end else if (s3.date.month == MON_JAN) begin
      // 31 + day - wd + 1 wraps to day - wd in five bits
      res_next.sunday_year  = s3.date.year - 14'd1;
      res_next.sunday_month = MON_DEC;
      res_next.sunday_day   = s3.date.day - DAY_W'(wd);
    end else begin
      res_next.sunday_year  = s3.date.year;
      res_next.sunday_month = pm;
      res_next.sunday_day   = plen + s3.date.day - DAY_W'(wd) + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && q_valid) begin
      out_data <= res_next;
    end
  end

endmodule

@@ hw/rtl/gregorian_weekday_week_start_day_count.sv @@
// Throughput: one date per cycle when the output does not stall; four register
// stages, each loads whenever it is empty or the stage after it moves, so a
// stall holds every stage intact.
// Reset (rst, synchronous): clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// gregorian_weekday_week_start_day_count
// Weekday, Sunday opening the week and day number of a Gregorian date.
// ----------------------------------------------------------------------------
`include "gregorian_weekday_week_start_day_count_defines.svh"

module gregorian_weekday_week_start_day_count import gwd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gwd_date_if.sink     dates,
  gwd_result_if.source results
);

  date_t   in_date;
  s1_t     s1;
  s2_t     s2;
  result_t res;
  logic    v1, v2, v3, v4;
  logic    load1, load2, load3, load4;

  assign load4 = !v4 || results.ready;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  assign dates.ready = load1;

  assign in_date.year  = dates.date_year;
  assign in_date.month = dates.date_month;
  assign in_date.day   = dates.date_day;

  gwd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .load      (load1),
    .in_valid  (dates.valid),
    .in_date   (in_date),
    .out_valid (v1),
    .out_data  (s1)
  );

  gwd_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .load      (load2),
    .in_valid  (v1),
    .in_data   (s1),
    .out_valid (v2),
    .out_data  (s2)
  );

  gwd_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .load_q    (load3),
    .load_out  (load4),
    .in_valid  (v2),
    .in_data   (s2),
    .q_valid   (v3),
    .out_valid (v4),
    .out_data  (res)
  );

  assign results.valid            = v4;
  assign results.weekday          = res.weekday;
  assign results.sunday_year      = res.sunday_year;
  assign results.sunday_month     = res.sunday_month;
  assign results.sunday_day       = res.sunday_day;
  assign results.days_since_epoch = res.days_since_epoch;

  `GWD_ASSERT_NOW(a_weekday_range, v4, res.weekday != 3'd0,
                  "weekday out of range")
  `GWD_ASSERT_NOW(a_sunday_day_nonzero, v4, res.sunday_day != 5'd0,
                  "week-start day is zero")
  `GWD_ASSERT_NEXT(a_stage3_holds, v3 && !load4, v3,
                   "stage 3 item lost during stall")
  `GWD_ASSERT_NEXT(a_stage1_holds, v1 && !load2, v1 && $stable(s1),
                   "stage 1 item changed during stall")

endmodule

@@ bench/gregorian_weekday_week_start_day_count_tb.sv @@
// ----------------------------------------------------------------------------
// gregorian_weekday_week_start_day_count_tb
// Self-checking bench for the weekday / week-start Sunday / day number block.
// Dates are sent over the valid/ready input channel and each one is predicted
// on transfer. Results are compared in order as they leave the output channel.
// Both sides may idle: the sender works in random bursts and the receiver
// follows its own stall pattern.
// ----------------------------------------------------------------------------
module gregorian_weekday_week_start_day_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gwd_pkg::*;

  localparam int IDLE_LIMIT  = 5000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 8;     // pipeline is 4 deep
  localparam int MAX_REPORTS = 40;

  localparam int unsigned DAY_COUNT_CAP = COUNT_MAX;

  // days before month 0..13 in a common year; 13 is a whole year
  localparam int unsigned DAYS_BEFORE[14] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };
  // common-year length for month codes 0..15; non-months read as 31
  localparam int unsigned COMMON_LEN[16] = '{
    31, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 31, 31
  };

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    date_t   dt;
    result_t res;
  } week_expect_t;

  logic clk;
  logic rst;

  gwd_date_if   date_ch ();
  gwd_result_if result_ch ();

  gregorian_weekday_week_start_day_count DUT (
    .clk     (clk),
    .rst     (rst),
    .dates   (date_ch),
    .results (result_ch)
  );

  week_expect_t pending_weeks[$];

  int          fails = 0;
  int          idle_cycles = 0;
  int          n_dates = 0;
  int          n_results = 0;
  int          n_prev_month = 0;
  int          n_prev_year = 0;
  int          n_saturated = 0;

  int          gap_max = 0;
  int          burst_left = 0;
  stall_mode_t resp_stall_mode = STALL_NONE;
  int          stall_pct = 0;
  int          stall_period = 1;
  int          stall_hold = 0;

  wire date_fire   = date_ch.valid && date_ch.ready;
  wire result_fire = result_ch.valid && result_ch.ready;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    if (m == 2 && is_leap_year(y)) return 29;
    return COMMON_LEN[m];
  endfunction

  function automatic result_t predict_week_and_count(input date_t dt);
    int unsigned y, m, d, mm, ya, s, wd, pm, plen, yp, mi, total;
    result_t     r;
    y  = dt.year;
    m  = dt.month;
    d  = dt.day;
    // Jan/Feb count as months 13/14 of the previous year; +400 keeps year 0 sane
    mm = m;
    ya = y + 400;
    if (m == 1 || m == 2) begin
      mm = m + 12;
      ya = ya - 1;
    end
    s  = d + 2 * mm + (3 * (mm + 1)) / 5 + ya + ya / 4 - ya / 100 + ya / 400;
    wd = ((s % 7) + 1) % 7 + 1;
    r.weekday = WDAY_W'(wd);

    if (d >= wd) begin
      r.sunday_year  = YEAR_W'(y);
      r.sunday_month = MONTH_W'(m);
      r.sunday_day   = DAY_W'(d - wd + 1);
    end else if (m == 1) begin
      r.sunday_year  = YEAR_W'(y - 1);  // year 0 wraps to all ones
      r.sunday_month = MONTH_W'(12);
      r.sunday_day   = DAY_W'(31 + d - wd + 1);
    end else begin
      pm   = (m - 1) & 4'hF;
      plen = COMMON_LEN[pm];
      if (pm == 2 && is_leap_year(y)) plen = 29;
      r.sunday_year  = YEAR_W'(y);
      r.sunday_month = MONTH_W'(pm);
      r.sunday_day   = DAY_W'(plen + d - wd + 1);
    end

    yp    = (y >= 1) ? y - 1 : 0;
    mi    = (m > 13) ? 13 : m;
    total = 365 * yp + yp / 4 - yp / 100 + yp / 400 + DAYS_BEFORE[mi];
    if (mi >= 3 && is_leap_year(y)) total = total + 1;
    if (d > 1) total = total + d - 1;
    if (total > DAY_COUNT_CAP) total = DAY_COUNT_CAP;
    r.days_since_epoch = COUNT_W'(total);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: pop before push so a stray result never meets a fresh date
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input date_t dt,
                             input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (fails < MAX_REPORTS)
        $display("%0t ns: %s mismatch for %0d-%0d-%0d: expected %0d, actual %0d",
                 $time, what, dt.year, dt.month, dt.day, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    week_expect_t ex;
    date_t        dt;
    if (!rst && result_fire) begin
      n_results++;
      if (pending_weeks.size() == 0) begin
        if (fails < MAX_REPORTS)
          $display("%0t ns: result with nothing expected: expected none, actual %0d %0d-%0d-%0d %0d",
                   $time, result_ch.weekday, result_ch.sunday_year, result_ch.sunday_month,
                   result_ch.sunday_day, result_ch.days_since_epoch);
        fails++;
      end else begin
        ex = pending_weeks.pop_front();
        check_field("weekday", ex.dt, ex.res.weekday, result_ch.weekday);
        check_field("sunday_year", ex.dt, ex.res.sunday_year, result_ch.sunday_year);
        check_field("sunday_month", ex.dt, ex.res.sunday_month, result_ch.sunday_month);
        check_field("sunday_day", ex.dt, ex.res.sunday_day, result_ch.sunday_day);
        check_field("days_since_epoch", ex.dt, ex.res.days_since_epoch,
                    result_ch.days_since_epoch);
      end
    end
    if (!rst && date_fire) begin
      dt.year  = date_ch.date_year;
      dt.month = date_ch.date_month;
      dt.day   = date_ch.date_day;
      ex.dt    = dt;
      ex.res   = predict_week_and_count(dt);
      pending_weeks.push_back(ex);
      n_dates++;
      if (ex.res.sunday_year != dt.year) n_prev_year++;
      else if (ex.res.sunday_month != dt.month) n_prev_month++;
      if (ex.res.days_since_epoch == COUNT_W'(DAY_COUNT_CAP)) n_saturated++;
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (rst || date_fire || result_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_weeks.size());
      $display("** gregorian_weekday_week_start_day_count: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  initial begin
    int cyc;
    cyc = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      case (resp_stall_mode)
        STALL_NONE:     result_ch.ready = 1'b1;
        STALL_RANDOM:   result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        STALL_PERIODIC: result_ch.ready = ((cyc % stall_period) >= stall_hold);
        default:        result_ch.ready = 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge after transfer
  // --------------------------------------------------------------------------
  task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
    if (gap_max > 0 && burst_left == 0) begin
      date_ch.valid = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    date_ch.valid      = 1'b1;
    date_ch.date_year  = YEAR_W'(y);
    date_ch.date_month = MONTH_W'(m);
    date_ch.date_day   = DAY_W'(d);
    @(posedge clk);
    while (!date_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic int unsigned pick_valid_year();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(9996, 9999);
      2:       return 100 * $urandom_range(1, 99) + $urandom_range(0, 1) - 0;
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    gap_max         = 3;
    resp_stall_mode = STALL_RANDOM;
    stall_pct       = 30;
    send_date(1, 1, 1);          // day number zero
    send_date(9999, 12, 31);     // last valid date
    send_date(0, 1, 1);          // Sunday wraps below year zero
    send_date(0, 2, 29);         // year zero is leap
    send_date(16383, 15, 31);    // every field at all ones, count saturates
    send_date(2024, 0, 0);       // month zero, day zero
    send_date(2023, 5, 0);       // day zero falls into previous month
    send_date(2024, 3, 1);       // previous month is a leap February
    send_date(1900, 3, 1);       // century, not leap
    send_date(2000, 3, 2);       // 400-year leap
    send_date(2024, 13, 15);     // month past December
    send_date(2024, 14, 3);
    for (int d = 1; d <= 7; d++) send_date(2023, 1, d);  // Sunday through Saturday
    send_date(2022, 1, 1);       // Sunday in December of the previous year
    send_date(2023, 3, 1);       // Sunday in a common February
    send_date(9999, 1, 1);
    send_date(5000, 9, 15);
  endtask

  task automatic test_random_valid_dates(input int count);
    int unsigned y, m;
    for (int i = 0; i < count; i++) begin
      // no idling for the first stretch, then rotate receiver patterns
      if (i == 0) begin
        gap_max         = 0;
        resp_stall_mode = STALL_NONE;
      end else if (i >= 300 && i % 100 == 0) begin
        gap_max = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0: resp_stall_mode = STALL_NONE;
          1: begin
            resp_stall_mode = STALL_RANDOM;
            stall_pct       = $urandom_range(10, 70);
          end
          default: begin
            resp_stall_mode = STALL_PERIODIC;
            stall_period    = $urandom_range(2, 9);
            stall_hold      = $urandom_range(1, stall_period - 1);
          end
        endcase
      end
      y = pick_valid_year();
      if (y == 0) y = 1;
      m = $urandom_range(1, 12);
      send_date(y, m, $urandom_range(1, days_in_month(y, m)));
    end
  endtask

  task automatic test_raw_fields(input int count);
    gap_max         = 4;
    resp_stall_mode = STALL_PERIODIC;
    stall_period    = 7;
    stall_hold      = 3;
    for (int i = 0; i < count; i++)
      send_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endtask

  task automatic test_week_start_boundaries(input int count);
    int unsigned y, m;
    gap_max         = 2;
    resp_stall_mode = STALL_RANDOM;
    stall_pct       = 50;
    for (int i = 0; i < count; i++) begin
      // first week of a month, years around century and leap boundaries
      y = ($urandom_range(0, 1) == 0) ? 100 * $urandom_range(1, 99) + $urandom_range(0, 4)
                                      : pick_valid_year();
      if (y == 0) y = 1;
      m = $urandom_range(1, 12);
      send_date(y, m, $urandom_range(1, 7));
    end
  endtask

  initial begin
    rst                = 1'b1;
    date_ch.valid      = 1'b0;
    date_ch.date_year  = '0;
    date_ch.date_month = '0;
    date_ch.date_day   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_valid_dates(1000);
    test_raw_fields(400);
    test_week_start_boundaries(100);

    date_ch.valid = 1'b0;
    while (pending_weeks.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results for %0d dates: %0d week starts in a prior month,",
             n_results, n_dates, n_prev_month);
    $display("%0d in a prior year, %0d saturated day numbers, %0d mismatches.",
             n_prev_year, n_saturated, fails);
    if (fails == 0) begin
      $display("** gregorian_weekday_week_start_day_count: PASSED **");
    end else begin
      $display("** gregorian_weekday_week_start_day_count: FAILED **");
    end
    $finish;
  end

endmodule
